### rtl/rvs_pkg.sv
// Shared types and constants of the RV32I subset step core.
`timescale 1ns / 1ps
package rvs_pkg;

  // Default memory depth in 32-bit words (a power of two).
  localparam int MEM_WORDS_DEF = 4096;

  // Input command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Major opcodes that the core executes.
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;

  localparam logic [2:0] F3_ZERO = 3'd0;
  localparam logic [6:0] F7_ZERO = 7'd0;

  // Register numbers of x0, sp and gp, and the nonzero reset values of sp and gp.
  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_SP   = 5'd2;
  localparam logic [4:0] REG_GP   = 5'd3;
  localparam logic [31:0] SP_RESET = 32'h0000_3FFC;
  localparam logic [31:0] GP_RESET = 32'h0000_1800;

  // One queued word from the input channel.
  typedef struct packed {
    logic        is_step;
    logic [11:0] word_address;
    logic [31:0] word_data;
  } item_t;

  // Head of the front queue as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // One result word.
  typedef struct packed {
    logic [31:0] pc_before;
    logic [31:0] instruction;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        byte_stored;
    logic [31:0] store_address;
    logic [7:0]  store_byte;
  } result_t;

endpackage

### rtl/rvs_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module rvs_front import rvs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept_en,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_cmd,
  input  logic [11:0] in_word_address,
  input  logic [31:0] in_word_data,
  output queue_head_t head,
  input  logic        pop
);

  item_t       q_mem [2];
  logic        wr_ptr_r;
  logic        wr_ptr_nxt;
  logic        rd_ptr_r;
  logic        rd_ptr_nxt;
  logic [1:0]  count_r;
  logic [1:0]  count_nxt;
  logic        push;
  item_t       new_item;

  assign in_tready = accept_en && (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;

  always_comb begin
    new_item.is_step      = (in_cmd == CMD_STEP);
    new_item.word_address = in_word_address;
    new_item.word_data    = in_word_data;
  end

  assign head.valid = (count_r != 2'd0);
  assign head.item  = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_item;
    end
  end

endmodule

### rtl/rvs_back.sv
// Back end: memory, register file, program counter and the step sequencer.
`timescale 1ns / 1ps
module rvs_back import rvs_pkg::*; #(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  queue_head_t head,
  output logic        pop,
  output logic        accept_en,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_res
);

  localparam int AW = $clog2(MEM_WORDS);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DECODE = 3'd2;
  localparam logic [2:0] ST_EXEC   = 3'd3;
  localparam logic [2:0] ST_MEM    = 3'd4;
  localparam logic [2:0] ST_RESULT = 3'd5;

  function automatic logic [31:0] imm_i(input logic [31:0] ir);
    imm_i = {{20{ir[31]}}, ir[31:20]};
  endfunction

  function automatic logic [31:0] imm_s(input logic [31:0] ir);
    imm_s = {{20{ir[31]}}, ir[31:25], ir[11:7]};
  endfunction

  function automatic logic [31:0] imm_b(input logic [31:0] ir);
    imm_b = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
  endfunction

  function automatic logic [31:0] imm_j(input logic [31:0] ir);
    imm_j = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
  endfunction

  function automatic logic [31:0] rf_reset_val(input logic [4:0] idx);
    if (idx == REG_SP) begin
      rf_reset_val = SP_RESET;
    end else if (idx == REG_GP) begin
      rf_reset_val = GP_RESET;
    end else begin
      rf_reset_val = 32'd0;
    end
  endfunction

  // Main memory, single port, registered read.
  logic [31:0]   mem [MEM_WORDS];
  logic [31:0]   mem_rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;

  // Register file: two registered reads, one write, per-entry valid bits.
  logic [31:0]   rf_mem [32];
  logic [31:0]   rf_vld_r;
  logic [31:0]   rs1_val_r;
  logic [31:0]   rs2_val_r;
  logic          rf_we;
  logic [4:0]    rf_waddr;
  logic [31:0]   rf_wdata;
  logic [4:0]    rd_rs1;
  logic [4:0]    rd_rs2;

  logic [2:0]    state_r;
  logic [2:0]    state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] clr_cnt_nxt;
  logic [31:0]   pc_r;
  logic [31:0]   pc_nxt;
  logic [AW+1:0] ls_addr_r;
  logic [AW+1:0] ls_addr_nxt;
  result_t       res_r;
  result_t       res_nxt;
  result_t       out_r;
  result_t       out_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;

  logic [31:0]   ir;
  logic [6:0]    op;
  logic [4:0]    rd;
  logic [2:0]    f3;
  logic [6:0]    f7;
  logic [31:0]   ls_sum;
  logic [4:0]    lane_sh;
  logic [7:0]    ld_byte;
  logic [31:0]   merged;
  logic          wb;
  logic [31:0]   wb_val;
  logic          out_free;

  assign ir = res_r.instruction;
  assign op = ir[6:0];
  assign rd = ir[11:7];
  assign f3 = ir[14:12];
  assign f7 = ir[31:25];

  assign ls_sum   = rs1_val_r + ((op == OP_STORE) ? imm_s(ir) : imm_i(ir));
  assign lane_sh  = {ls_addr_r[1:0], 3'b000};
  assign ld_byte  = mem_rdata_r[lane_sh +: 8];
  assign rd_rs1   = mem_rdata_r[19:15];
  assign rd_rs2   = mem_rdata_r[24:20];
  assign out_free = !out_valid_r || out_ready;

  assign accept_en = (state_r != ST_CLEAR);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    merged = mem_rdata_r;
    merged[lane_sh +: 8] = rs2_val_r[7:0];
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    pc_nxt        = pc_r;
    ls_addr_nxt   = ls_addr_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = '0;
    mem_wdata     = 32'd0;
    rf_we         = 1'b0;
    rf_waddr      = rd;
    rf_wdata      = 32'd0;
    wb            = 1'b0;
    wb_val        = 32'd0;

    // Drop the output word once taken; a new one may replace it below.
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {AW{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head.valid) begin
          pop     = 1'b1;
          res_nxt = '0;
          if (head.item.is_step) begin
            mem_addr          = pc_r[AW+1:2];
            res_nxt.pc_before = pc_r;
            pc_nxt            = pc_r + 32'd4;
            state_nxt         = ST_DECODE;
          end else begin
            mem_we    = 1'b1;
            mem_addr  = AW'(head.item.word_address);
            mem_wdata = head.item.word_data;
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_DECODE: begin
        res_nxt.instruction = mem_rdata_r;
        state_nxt           = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_RESULT;
        unique case (op)
          OP_LUI: begin
            wb     = 1'b1;
            wb_val = {ir[31:12], 12'd0};
          end
          OP_JAL: begin
            wb     = 1'b1;
            wb_val = res_r.pc_before + 32'd4;
            pc_nxt = res_r.pc_before + imm_j(ir);
          end
          OP_BRANCH: begin
            if (f3 == F3_ZERO && rs1_val_r == rs2_val_r) begin
              pc_nxt = res_r.pc_before + imm_b(ir);
            end
          end
          OP_LOAD, OP_STORE: begin
            if (f3 == F3_ZERO) begin
              ls_addr_nxt = ls_sum[AW+1:0];
              mem_addr    = ls_sum[AW+1:2];
              state_nxt   = ST_MEM;
            end
          end
          OP_IMM: begin
            if (f3 == F3_ZERO) begin
              wb     = 1'b1;
              wb_val = rs1_val_r + imm_i(ir);
            end
          end
          OP_REG: begin
            if (f3 == F3_ZERO && f7 == F7_ZERO) begin
              wb     = 1'b1;
              wb_val = rs1_val_r + rs2_val_r;
            end
          end
          default: begin
          end
        endcase
      end
      ST_MEM: begin
        state_nxt = ST_RESULT;
        if (op == OP_LOAD) begin
          wb     = 1'b1;
          wb_val = {{24{ld_byte[7]}}, ld_byte};
        end else begin
          mem_we                = 1'b1;
          mem_addr              = ls_addr_r[AW+1:2];
          mem_wdata             = merged;
          res_nxt.byte_stored   = 1'b1;
          res_nxt.store_address = 32'(ls_addr_r);
          res_nxt.store_byte    = rs2_val_r[7:0];
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Write back, skipping x0.
    if (wb && rd != REG_ZERO) begin
      rf_we               = 1'b1;
      rf_wdata            = wb_val;
      res_nxt.reg_written = 1'b1;
      res_nxt.reg_index   = rd;
      res_nxt.reg_value   = wb_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= 32'd0;
      out_valid_r <= 1'b0;
      rf_vld_r    <= 32'd0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      if (rf_we) begin
        rf_vld_r[rf_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ls_addr_r <= ls_addr_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    if (state_r == ST_DECODE) begin
      rs1_val_r <= rf_vld_r[rd_rs1] ? rf_mem[rd_rs1] : rf_reset_val(rd_rs1);
      rs2_val_r <= rf_vld_r[rd_rs2] ? rf_mem[rd_rs2] : rf_reset_val(rd_rs2);
    end
  end

  a_mem_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_IDLE || state_r == ST_MEM))
    else $error("memory written outside clear, idle or memory phase");

  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> (rf_waddr != REG_ZERO))
    else $error("write to x0");

  a_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == ST_IDLE || state_r == ST_EXEC) |=> $stable(pc_r))
    else $error("pc changed outside fetch or execute");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not presented");

endmodule

### rtl/rv32i_subset_core_step_core.sv
// Top level of the RV32I subset step core: stream ports, front queue and back end.
`timescale 1ns / 1ps
// Usage:
//   Input words arrive on in_t*. in_tuser is the command: 0 loads word_data into
//   memory word word_address (wrapped to the memory size), 1 runs one instruction
//   at pc. Every input word yields exactly one result word on out_t*, in order.
//   A memory load reports all-zero fields; a step reports pc, the fetched
//   instruction, any register write-back and any byte store.
// Sequence (output free): a step runs fetch, register read, execute (issues the
//   data read of a load or store), a data phase for the load byte or the store
//   write of the merged word, and a move of the result into the output register.
//   A memory load writes its word and then moves its result out. Fetch and data
//   access share the single memory port. The back end takes the next input word
//   only once the last result is in the output register.
// Reset: rst_n low synchronously clears pc, the register file (sp and gp take
//   their start values) and the queue. After reset the back end zeroes the
//   memory, one word per cycle, through all MEM_WORDS words; in_tready stays low then.
// Stall: a result waits in the output register; the back end holds the next
//   result until it is taken. The two-word input queue keeps accepting until it
//   is full, then in_tready drops until the back end pops a word.
module rv32i_subset_core_step_core import rvs_pkg::*; #(
  parameter int MEM_WORDS = MEM_WORDS_DEF   // memory depth in words, power of two
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // word_address[11:0], word_data[43:12], zero pad
  input  logic         in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  // pc_before[31:0], instruction[63:32], reg_index[68:64], reg_value[100:69],
  // store_address[132:101], store_byte[140:133], zero pad
  output logic [143:0] out_tdata,
  output logic [1:0]   out_tuser   // reg_written[0], byte_stored[1]
);

  queue_head_t head;
  logic        pop;
  logic        accept_en;
  result_t     res;

  // Front: classify and queue input words.
  rvs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept_en       (accept_en),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_cmd          (in_tuser),
    .in_word_address (in_tdata[11:0]),
    .in_word_data    (in_tdata[43:12]),
    .head            (head),
    .pop             (pop)
  );

  // Back: execute queued words and hold the result for the receiver.
  rvs_back #(
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .accept_en (accept_en),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result word; flags go out on tuser.
  assign out_tdata = {3'b000, res.store_byte, res.store_address, res.reg_value,
                      res.reg_index, res.instruction, res.pc_before};
  assign out_tuser = {res.byte_stored, res.reg_written};

endmodule
